// ----- src/ipt_pkg.sv -----
// ipt_pkg: types and constants shared by the IPv4 text parser.
// Holds the scan phase, the parse state record and the result record.
// No dependencies.
package ipt_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned ACC_W     = 24;
	localparam int unsigned OCTET_W   = 8;
	localparam int unsigned WIDE_W    = 12;    // octet * 10 + digit

	localparam logic [LEN_W-1:0]   LEN_MAX     = 4'd15;
	localparam logic [WIDE_W-1:0]  OCTET_MAX   = 12'd255;
	localparam logic [1:0]         LAST_OCTET  = 2'd3;
	localparam logic [1:0]         MAX_DIGITS  = 2'd3;
	localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;

	localparam logic [CHAR_W-1:0]  CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0]  CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0]  CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0]  CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0]  CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0]  CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0]  CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CH_NINE  = 8'h39;

	// configuration register indexes
	localparam logic CFG_TOKEN_MODE = 1'b0;
	localparam logic CFG_CAPACITY   = 1'b1;

	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_TOKEN  = 2'd1,
		PH_TRAIL  = 2'd2,
		PH_IGNORE = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic                failed;
		logic [1:0]          octet_index;
		logic [1:0]          digit_count;
		logic [OCTET_W-1:0]  octet_value;
		logic [ACC_W-1:0]    acc;
		logic [LEN_W-1:0]    length;
	} parse_state_t;

	typedef struct packed {
		logic               address_valid;
		logic [ADDR_W-1:0]  address;
		logic [LEN_W-1:0]   text_length;
	} result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:       PH_LEAD,
		failed:      1'b0,
		octet_index: 2'd0,
		digit_count: 2'd0,
		octet_value: '0,
		acc:         '0,
		length:      '0
	};

endpackage

// ----- src/ipt_step.sv -----
// ipt_step: per-character update of the parse state and the end-of-text result.
// Purely combinational; uses ipt_pkg.
module ipt_step (
	input  ipt_pkg::parse_state_t           cur,
	input  logic [ipt_pkg::CHAR_W-1:0]      character,
	input  logic                            end_of_text,
	input  logic                            token_mode,
	input  logic [ipt_pkg::CAP_W-1:0]       output_capacity,
	output ipt_pkg::parse_state_t           nxt,
	output ipt_pkg::result_t                result
);
	import ipt_pkg::*;

	logic                is_space;
	logic                is_digit;
	logic [WIDE_W-1:0]   wide_val;
	logic                ok;
	parse_state_t        tok;    // state after taking a token character

	assign is_space = (character == CH_SPACE) || (character == CH_CR) ||
	                  (character == CH_LF) || (character == CH_TAB);
	assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
	assign wide_val = {1'b0, cur.octet_value, 3'b000} + {3'b000, cur.octet_value, 1'b0}
	                + {8'd0, character[3:0]};

	always_comb begin
		tok = cur;
		tok.phase = PH_TOKEN;
		if (cur.length == LEN_MAX) begin
			tok.failed = 1'b1;
		end else begin
			tok.length = cur.length + LEN_W'(1);
		end
		if (!tok.failed) begin
			if (is_digit) begin
				if (cur.digit_count == MAX_DIGITS || wide_val > OCTET_MAX) begin
					tok.failed = 1'b1;
				end else begin
					tok.octet_value = wide_val[OCTET_W-1:0];
					tok.digit_count = cur.digit_count + 2'd1;
				end
			end else if (character == CH_DOT) begin
				if (cur.digit_count == 2'd0 || cur.octet_index == LAST_OCTET) begin
					tok.failed = 1'b1;
				end else begin
					tok.acc         = {cur.acc[ACC_W-OCTET_W-1:0], cur.octet_value};
					tok.octet_index = cur.octet_index + 2'd1;
					tok.digit_count = 2'd0;
					tok.octet_value = '0;
				end
			end else begin
				tok.failed = 1'b1;
			end
		end
	end

	always_comb begin
		nxt = cur;
		if (end_of_text) begin
			nxt = STATE_RESET;
		end else if (character == CH_NUL) begin
			// string terminator: the rest up to the end marker is dropped
			nxt.phase = PH_IGNORE;
		end else begin
			unique case (cur.phase)
				PH_LEAD: begin
					if (!is_space) begin
						nxt = tok;
					end
				end
				PH_TOKEN: begin
					if (is_space) begin
						nxt.phase = token_mode ? PH_IGNORE : PH_TRAIL;
					end else begin
						nxt = tok;
					end
				end
				PH_TRAIL: begin
					if (!is_space) begin
						nxt.failed = 1'b1;
					end
				end
				PH_IGNORE: begin
					nxt = cur;
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

	assign ok = !cur.failed && (cur.phase != PH_LEAD) && (cur.length != '0) &&
	            (cur.octet_index == LAST_OCTET) && (cur.digit_count != 2'd0) &&
	            ({1'b0, cur.length} < output_capacity);

	always_comb begin
		result.address_valid = ok;
		result.address       = ok ? {cur.acc, cur.octet_value} : '0;
		result.text_length   = ok ? cur.length : '0;
	end

endmodule

// ----- src/ipv4_text_parser.sv -----
// ipv4_text_parser: dotted-decimal IPv4 checker over a character stream.
// Top level; instantiates ipt_step, uses ipt_pkg.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, character, end_of_text | in
//   out     | out_valid, out_stall, address_valid,      | out
//           | address, text_length                      |
//   cfg     | cfg_we, cfg_index, cfg_data               | in
//
// One character per cycle while in_stall is low: input register, state update, result register.
// A result is presented after its end marker passes from the input register into the result register.
// in_stall rises only when an end marker sits in the input register while the
// result register is full and stalled; plain characters keep flowing.
// Reset clears the parse state, token_mode to 0 and output_capacity to 16.
module ipv4_text_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ipt_pkg::CHAR_W-1:0]   character,
	input  logic                         end_of_text,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         address_valid,
	output logic [ipt_pkg::ADDR_W-1:0]   address,
	output logic [ipt_pkg::LEN_W-1:0]    text_length,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ipt_pkg::CAP_W-1:0]    cfg_data
);
	import ipt_pkg::*;

	logic                 valid_s1;
	logic [CHAR_W-1:0]    char_s1;
	logic                 eot_s1;
	logic                 fire_s1;
	logic                 in_xfer;
	logic                 token_mode_q;
	logic [CAP_W-1:0]     capacity_q;
	parse_state_t         state_q;
	parse_state_t         state_nxt;
	result_t              result_nxt;
	result_t              result_q;
	logic                 out_valid_q;

	assign fire_s1  = valid_s1 && (!eot_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire_s1;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_mode_q <= 1'b0;
			capacity_q   <= CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOKEN_MODE: token_mode_q <= cfg_data[0];
				CFG_CAPACITY:   capacity_q   <= cfg_data;
				default:        token_mode_q <= token_mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= character;
			eot_s1  <= end_of_text;
		end
	end

	ipt_step u_step (
		.cur             (state_q),
		.character       (char_s1),
		.end_of_text     (eot_s1),
		.token_mode      (token_mode_q),
		.output_capacity (capacity_q),
		.nxt             (state_nxt),
		.result          (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && eot_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && eot_s1) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign address_valid = result_q.address_valid;
	assign address       = result_q.address;
	assign text_length   = result_q.text_length;

endmodule

// ----- tb/ipv4_text_parser_tb.sv -----
// ipv4_text_parser_tb: self-checking testbench for the IPv4 text parser.
// Needs ipt_pkg and ipv4_text_parser; runs a directed text table and then random
// texts under several register settings, checking every result against a known value or a predictor.
`timescale 1ns / 1ps

module ipv4_text_parser_tb;
	import ipt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TOTAL_CHARS = 1950;
	localparam int SETTLE_CYCLES = 4;
	localparam int N_DIR = 23;
	localparam int N_PHASES = 8;
	localparam logic [CHAR_W-1:0] NUL_MARK = "@";    // stands for a zero byte in the table

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CHAR_W-1:0]   character = '0;
	logic                end_of_text = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                address_valid;
	logic [ADDR_W-1:0]   address;
	logic [LEN_W-1:0]    text_length;
	logic                cfg_we = 1'b0;
	logic                cfg_index = CFG_TOKEN_MODE;
	logic [CAP_W-1:0]    cfg_data = '0;

	ipv4_text_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.character(character), .end_of_text(end_of_text),
		.out_valid(out_valid), .out_stall(out_stall),
		.address_valid(address_valid), .address(address), .text_length(text_length),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	bit                  mode_token;
	int                  capacity;
	phase_t              scan_phase;
	bit                  scan_failed;
	int                  octet_idx;
	int                  digits;
	logic [OCTET_W-1:0]  octet;
	logic [ACC_W-1:0]    acc;
	int                  addr_len;

	result_t             pending_results[$];
	logic [CHAR_W-1:0]   text_buf[$];
	int                  mismatches = 0;
	int                  chars_sent = 0;
	int                  burst_left = 0;

	function automatic bit is_blank(logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB;
	endfunction

	task automatic clear_scan();
		scan_phase = PH_LEAD;
		scan_failed = 1'b0;
		octet_idx = 0;
		digits = 0;
		octet = '0;
		acc = '0;
		addr_len = 0;
	endtask

	task automatic take_addr_char(logic [CHAR_W-1:0] c);
		int v;
		if (addr_len >= int'(LEN_MAX)) begin
			scan_failed = 1'b1;
		end else begin
			addr_len++;
		end
		if (scan_failed)
			return;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = int'(octet) * 10 + int'(c) - int'(CH_ZERO);
			if (digits >= 3 || v > 255) begin
				scan_failed = 1'b1;
			end else begin
				octet = v[7:0];
				digits++;
			end
		end else if (c == CH_DOT) begin
			if (digits == 0 || octet_idx >= 3) begin
				scan_failed = 1'b1;
			end else begin
				acc = {acc[ACC_W-OCTET_W-1:0], octet};
				octet_idx++;
				digits = 0;
				octet = '0;
			end
		end else begin
			scan_failed = 1'b1;
		end
	endtask

	task automatic scan_char(logic [CHAR_W-1:0] c);
		if (c == CH_NUL) begin
			scan_phase = PH_IGNORE;
			return;
		end
		case (scan_phase)
			PH_LEAD: begin
				if (!is_blank(c)) begin
					scan_phase = PH_TOKEN;
					take_addr_char(c);
				end
			end
			PH_TOKEN: begin
				if (is_blank(c))
					scan_phase = mode_token ? PH_IGNORE : PH_TRAIL;
				else
					take_addr_char(c);
			end
			PH_TRAIL: begin
				if (!is_blank(c))
					scan_failed = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic close_text(output result_t r);
		bit ok;
		ok = !scan_failed && scan_phase != PH_LEAD && addr_len > 0 && octet_idx == 3 &&
			digits > 0 && addr_len < capacity;
		r.address_valid = ok;
		r.address = ok ? {acc, octet} : '0;
		r.text_length = ok ? addr_len[LEN_W-1:0] : '0;
		clear_scan();
	endtask

	// ---------------- driving ----------------
	task automatic send_item(logic [CHAR_W-1:0] c, logic eot);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		character <= c;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (in_stall);
		burst_left--;
	endtask

	task automatic send_text(bit known, result_t typed);
		result_t r;
		foreach (text_buf[i]) begin
			send_item(text_buf[i], 1'b0);
			scan_char(text_buf[i]);
			chars_sent++;
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
		chars_sent++;
		close_text(r);
		pending_results.push_back(known ? typed : r);
	endtask

	// hold off until every result is back and the pipe has emptied
	task automatic drain(bit settle);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(bit tok, int cap);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TOKEN_MODE;
		cfg_data <= {4'($urandom), tok};    // upper bits are don't-care
		@(posedge clk);
		cfg_index <= CFG_CAPACITY;
		cfg_data <= cap[CAP_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_token = tok;
		capacity = cap;
	endtask

	// ---------------- random texts ----------------
	function automatic logic [CHAR_W-1:0] rand_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	task automatic push_octet(int val);
		int nd;
		int p;
		nd = (val >= 100) ? 3 : (val >= 10) ? 2 : 1;
		if ($urandom_range(0, 3) == 0)
			nd = $urandom_range(nd, 3);    // leading zeros
		for (int k = nd - 1; k >= 0; k--) begin
			p = (k == 2) ? 100 : (k == 1) ? 10 : 1;
			text_buf.push_back(CH_ZERO + 8'((val / p) % 10));
		end
	endtask

	task automatic make_text();
		int kind;
		int val;
		int pos;
		text_buf.delete();
		kind = $urandom_range(0, 11);
		if (kind < 9) begin
			repeat ($urandom_range(0, 2)) text_buf.push_back(rand_blank());
			for (int o = 0; o < 4; o++) begin
				if (o > 0)
					text_buf.push_back(CH_DOT);
				case ($urandom_range(0, 5))
					0: val = 0;
					1: val = 255;
					default: val = $urandom_range(0, 255);
				endcase
				push_octet(val);
			end
			case ($urandom_range(0, 5))
				1: repeat ($urandom_range(1, 3)) text_buf.push_back(rand_blank());
				2: begin
					text_buf.push_back(rand_blank());
					repeat ($urandom_range(1, 4))
						text_buf.push_back(8'($urandom_range(33, 126)));
				end
				3: begin
					text_buf.push_back(CH_NUL);
					repeat ($urandom_range(0, 3))
						text_buf.push_back(8'($urandom_range(0, 255)));
				end
				4: text_buf.push_back(8'($urandom_range(0, 255)));
				default: ;
			endcase
			// corrupt some of the well-formed ones
			if (kind >= 6 && text_buf.size() > 0) begin
				pos = $urandom_range(0, text_buf.size() - 1);
				case ($urandom_range(0, 2))
					0: text_buf[pos] = 8'($urandom_range(0, 255));
					1: text_buf.delete(pos);
					default: text_buf.insert(pos, ($urandom_range(0, 1) != 0) ? CH_DOT
						: CH_ZERO + 8'($urandom_range(0, 9)));
				endcase
			end
		end else if (kind < 11) begin
			repeat ($urandom_range(0, 20)) begin
				case ($urandom_range(0, 3))
					0: text_buf.push_back(8'($urandom_range(0, 255)));
					1: text_buf.push_back(rand_blank());
					2: text_buf.push_back(CH_DOT);
					default: text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				endcase
			end
		end else begin
			// long run of digits and dots
			repeat ($urandom_range(14, 22))
				text_buf.push_back(($urandom_range(0, 3) == 0) ? CH_DOT
					: CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	// ---------------- directed table ----------------
	typedef struct {
		bit      tok;
		int      cap;
		string   txt;
		bit      known;
		result_t want;
	} dir_row_t;

	localparam result_t NO_ADDR = '0;

	dir_row_t dir_rows [N_DIR] = '{
		'{0, 16, "",                          1, NO_ADDR},
		'{0, 16, "255.255.255.255",           1, '{1'b1, 32'hFFFF_FFFF, 4'd15}},
		'{0, 16, "0.0.0.0",                   1, '{1'b1, 32'h0000_0000, 4'd7}},
		'{0, 16, " \t\015\n9.8.7.6\015\n \t", 1, '{1'b1, 32'h0908_0706, 4'd7}},
		'{0, 16, "1.2.3.4 x",                 1, NO_ADDR},
		'{0, 16, "256.1.1.1",                 1, NO_ADDR},
		'{0, 16, "1.2.3",                     1, NO_ADDR},
		'{0, 16, "1.2..3",                    1, NO_ADDR},
		'{0, 16, "01.002.3.4.",               1, NO_ADDR},
		'{0, 16, "0001.2.3.4",                1, NO_ADDR},
		'{0, 16, "1.2.3.4@x y",               0, NO_ADDR},
		'{0, 16, "1.2.3.4\377",               1, NO_ADDR},
		'{0, 16, "1.2.3.4.5.6.7.8.9",         1, NO_ADDR},
		'{0, 16, "@1.2.3.4",                  1, NO_ADDR},
		'{0, 16, "a",                         1, NO_ADDR},
		'{1, 16, " 10.20.30.40 junk\t!",      0, NO_ADDR},
		'{1, 16, "1.2.3.4\t\t",               0, NO_ADDR},
		'{1, 16, "1.2.3.4@ 5",                0, NO_ADDR},
		'{1, 7,  "1.2.3.4",                   1, NO_ADDR},
		'{1, 8,  "1.2.3.4",                   0, NO_ADDR},
		'{0, 0,  "1.2.3.4",                   1, NO_ADDR},
		'{0, 1,  "",                          1, NO_ADDR},
		'{0, 31, "192.168.100.200",           0, NO_ADDR}
	};

	bit phase_tok [N_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};
	int phase_cap [N_PHASES] = '{16, 16, 31, 15, 8, 0, 1, -1};    // -1: pick at random

	// ---------------- checking ----------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: valid %b address %h length %0d",
					address_valid, address, text_length);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (address_valid !== want.address_valid) begin
					$error("address_valid: expected %b, got %b", want.address_valid,
						address_valid);
					mismatches++;
				end
				if (address !== want.address) begin
					$error("address: expected %h, got %h", want.address, address);
					mismatches++;
				end
				if (text_length !== want.text_length) begin
					$error("text_length: expected %0d, got %0d", want.text_length,
						text_length);
					mismatches++;
				end
			end
		end
	end

	// receiver backpressure: steps in turn through no stall, light and heavy random stall and a periodic pattern
	int stall_tick = 0;
	always @(posedge clk) begin
		stall_tick++;
		case ((stall_tick / 300) % 4)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= ((stall_tick % 5) < 2);
		endcase
	end

	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		int cur_cap;
		bit cur_tok;
		int target;
		mode_token = 1'b0;
		capacity = int'(CAP_RESET);
		clear_scan();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_tok = 1'b0;
		cur_cap = int'(CAP_RESET);
		foreach (dir_rows[r]) begin
			if (dir_rows[r].tok != cur_tok || dir_rows[r].cap != cur_cap) begin
				drain(1'b1);
				apply_config(dir_rows[r].tok, dir_rows[r].cap);
				cur_tok = dir_rows[r].tok;
				cur_cap = dir_rows[r].cap;
			end
			text_buf.delete();
			for (int i = 0; i < dir_rows[r].txt.len(); i++)
				text_buf.push_back(dir_rows[r].txt[i] == NUL_MARK ? CH_NUL
					: dir_rows[r].txt[i]);
			send_text(dir_rows[r].known, dir_rows[r].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain(1'b1);
			if (phase_cap[p] < 0)
				apply_config(1'($urandom_range(0, 1)), int'($urandom_range(0, 31)));
			else
				apply_config(phase_tok[p], phase_cap[p]);
			target = (p + 1) * TOTAL_CHARS / N_PHASES;
			while (chars_sent < target) begin
				make_text();
				send_text(1'b0, NO_ADDR);
				if ($urandom_range(0, 24) == 0)
					drain(1'b0);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
